### rtl/core/assert_macros.svh
// Assertion macros shared by the checker modules of the execute core.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/mie_pkg.sv
// Shared types and constants of the I-type execute core.
// No dependencies; imported by the core, its register file and its checker.
package mie_pkg;

	// Instruction codes carried in the mode field.
	typedef enum logic [3:0] {
		OP_BEQ  = 4'd0,
		OP_BNE  = 4'd1,
		OP_ADDI = 4'd2,
		OP_ANDI = 4'd3,
		OP_ORI  = 4'd4,
		OP_NORI = 4'd5,
		OP_LUI  = 4'd6,
		OP_SLTI = 4'd7,
		OP_LW   = 4'd8,
		OP_LH   = 4'd9,
		OP_LHU  = 4'd10,
		OP_LB   = 4'd11,
		OP_LBU  = 4'd12,
		OP_SW   = 4'd13,
		OP_SH   = 4'd14,
		OP_SB   = 4'd15
	} op_t;

	// Completion status reported with each result word.
	typedef enum logic [1:0] {
		ST_NORMAL   = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_SKIP     = 2'd2,
		ST_HALT     = 2'd3
	} status_t;

	// Register file write port.
	typedef struct packed {
		logic        we;
		logic [4:0]  addr;
		logic [31:0] data;
	} rf_wr_t;

endpackage

### rtl/core/mie_regfile.sv
// 32 x 32-bit register file with two registered read ports and one write port.
// Depends on mie_pkg for the write port type; per-entry valid bits give zeros after reset.
module mie_regfile import mie_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [4:0]  ra_idx,
	input  logic [4:0]  rb_idx,
	input  rf_wr_t      wr,
	output logic [31:0] ra_data,
	output logic [31:0] rb_data
);

	logic [31:0] mem_q [32];
	logic [31:0] valid_q;
	logic [31:0] ra_q;
	logic [31:0] rb_q;

	// An entry reads as zero until it has been written once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en && wr.we) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	// Write and registered reads; a read of the entry being written returns the new data.
	always_ff @(posedge clk) begin
		if (en) begin
			if (wr.we) begin
				mem_q[wr.addr] <= wr.data;
			end
			if (wr.we && wr.addr == ra_idx) begin
				ra_q <= wr.data;
			end else if (valid_q[ra_idx]) begin
				ra_q <= mem_q[ra_idx];
			end else begin
				ra_q <= '0;
			end
			if (wr.we && wr.addr == rb_idx) begin
				rb_q <= wr.data;
			end else if (valid_q[rb_idx]) begin
				rb_q <= mem_q[rb_idx];
			end else begin
				rb_q <= '0;
			end
		end
	end

	assign ra_data = ra_q;
	assign rb_data = rb_q;

endmodule

### rtl/core/mie_dmem.sv
// Word-wide data memory with one registered read port and one write port.
// No package dependency; after reset a sweep writes zeros to every word while busy is high.
module mie_dmem #(
	parameter int WORDS = 256,
	parameter int IDX_W = $clog2(WORDS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [IDX_W-1:0] rd_idx,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  logic [31:0]      wr_data,
	output logic [31:0]      rd_data,
	output logic             busy
);

	logic [31:0]      mem_q [WORDS];
	logic [31:0]      rd_q;
	logic             busy_q;
	logic [IDX_W-1:0] clr_idx_q;

	// Clearing sweep, one word per cycle after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_idx_q <= '0;
		end else if (busy_q) begin
			if (clr_idx_q == IDX_W'(WORDS - 1)) begin
				busy_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	// Memory array; a read of the word being written returns the new word.
	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem_q[clr_idx_q] <= '0;
		end else if (en) begin
			if (wr_en) begin
				mem_q[wr_idx] <= wr_data;
			end
			if (wr_en && wr_idx == rd_idx) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem_q[rd_idx];
			end
		end
	end

	assign rd_data = rd_q;
	assign busy    = busy_q;

endmodule

### rtl/core/mips_itype_execute_core.sv
// Top level of the I-type execute core: three-stage pipeline over the register
// file and data memory. Depends on mie_pkg, mie_regfile and mie_dmem.
//
//  Channel | Dir | Handshake        | Word
//  s       | in  | s_tvalid/s_tready | mode, src_reg, dst_reg, immediate, current_pc
//  m       | out | m_tvalid/m_tready | next_pc, status, zero_write_error,
//          |     |                   | number_overflow, address_overflow, misaligned
//
// One word is accepted per cycle while s_tready is high; its result reaches m through
// the registered register file read, the registered data memory read, and the output
// register. Results of an instruction reach the next one through forwarding, so
// dependent words follow each other without gaps.
// After reset s_tready stays low while the data memory is cleared. A result held on m
// with m_tready low freezes the whole pipeline.
module mips_itype_execute_core import mie_pkg::*; #(
	parameter int MEM_BYTES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [3:0] mode, [8:4] src_reg, [13:9] dst_reg, [29:14] immediate,
	// [61:30] current_pc, [63:62] zero
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [31:0] next_pc, [33:32] status, [34] zero_write_error, [35] number_overflow,
	// [36] address_overflow, [37] misaligned, [39:38] zero
	output logic [39:0] m_tdata
);

	localparam int WORDS = (MEM_BYTES + 3) / 4;
	localparam int IDX_W = $clog2(WORDS);

	typedef struct packed {
		logic        mis;
		logic        aov;
		logic        nov;
		logic        zw;
		status_t     status;
		logic [31:0] next_pc;
	} res_t;

	function automatic logic [31:0] sext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sext8(input logic [7:0] v);
		return {{24{v[7]}}, v};
	endfunction

	logic adv;
	logic accept;
	logic mem_busy;

	// Stage 1 registers
	logic        v_s1;
	op_t         op_s1;
	logic [4:0]  src_s1;
	logic [4:0]  dst_s1;
	logic [15:0] imm_s1;
	logic [31:0] pc_s1;

	// Stage 2 registers
	logic             v_s2;
	op_t              op_s2;
	logic [4:0]       dst_s2;
	logic [1:0]       lane_s2;
	logic [31:0]      alu_s2;
	logic [31:0]      b_s2;
	logic             rf_we_s2;
	logic             dm_we_s2;
	logic [IDX_W-1:0] idx_s2;
	res_t             res_s2;

	// Output register
	logic        out_v_q;
	res_t        out_q;

	logic [31:0] ra_raw;
	logic [31:0] rb_raw;
	logic [31:0] dm_rdata;
	rf_wr_t      rf_wr;

	// The whole pipeline moves together unless a result is held on the output.
	assign adv      = !out_v_q || m_tready;
	assign s_tready = adv && !mem_busy;
	assign accept   = s_tvalid && s_tready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1  <= op_t'(s_tdata[3:0]);
			src_s1 <= s_tdata[8:4];
			dst_s1 <= s_tdata[13:9];
			imm_s1 <= s_tdata[29:14];
			pc_s1  <= s_tdata[61:30];
		end
	end

	mie_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.ra_idx  (s_tdata[8:4]),
		.rb_idx  (s_tdata[13:9]),
		.wr      (rf_wr),
		.ra_data (ra_raw),
		.rb_data (rb_raw)
	);

	// Stage 1: operands with forwarding from stage 2, address, flags and ALU.
	logic [31:0] s2_wdata;
	logic        s2_fwd_we;
	logic [31:0] a_s1;
	logic [31:0] b_s1;
	logic [31:0] simm_s1;
	logic [31:0] zimm_s1;
	logic [31:0] sum_s1;
	logic        is_mem_s1;
	logic        writes_s1;
	logic        stores_s1;
	logic        zw_s1;
	logic        nov_s1;
	logic        aov_s1;
	logic        mis_s1;
	logic        branch_s1;
	logic        taken_s1;
	logic        commit_s1;
	status_t     status_s1;
	logic [31:0] alu_s1;

	assign s2_fwd_we = v_s2 && rf_we_s2;
	assign a_s1      = (s2_fwd_we && dst_s2 == src_s1) ? s2_wdata : ra_raw;
	assign b_s1      = (s2_fwd_we && dst_s2 == dst_s1) ? s2_wdata : rb_raw;
	assign simm_s1   = sext16(imm_s1);
	assign zimm_s1   = {16'h0000, imm_s1};
	assign sum_s1    = a_s1 + simm_s1;

	assign is_mem_s1 = op_s1[3];
	assign branch_s1 = (op_s1 == OP_BEQ) || (op_s1 == OP_BNE);
	assign stores_s1 = (op_s1 == OP_SW) || (op_s1 == OP_SH) || (op_s1 == OP_SB);
	assign writes_s1 = !branch_s1 && !stores_s1;
	assign zw_s1     = writes_s1 && (dst_s1 == 5'd0);
	assign nov_s1    = ((op_s1 == OP_ADDI) || is_mem_s1) && (a_s1[31] == simm_s1[31])
		&& (sum_s1[31] != a_s1[31]);
	assign aov_s1    = is_mem_s1 && (sum_s1 >= 32'(MEM_BYTES));

	always_comb begin
		case (op_s1)
			OP_LW, OP_SW:          mis_s1 = (sum_s1[1:0] != 2'b00);
			OP_LH, OP_LHU, OP_SH:  mis_s1 = sum_s1[0];
			default:               mis_s1 = 1'b0;
		endcase
	end

	// Halt outranks a skipped write, which outranks overflow.
	always_comb begin
		if (aov_s1 || mis_s1) begin
			status_s1 = ST_HALT;
		end else if (zw_s1) begin
			status_s1 = ST_SKIP;
		end else if (nov_s1) begin
			status_s1 = ST_OVERFLOW;
		end else begin
			status_s1 = ST_NORMAL;
		end
	end

	assign taken_s1  = ((op_s1 == OP_BEQ) && (a_s1 == b_s1))
		|| ((op_s1 == OP_BNE) && (a_s1 != b_s1));
	assign commit_s1 = v_s1 && !branch_s1
		&& ((status_s1 == ST_NORMAL) || (status_s1 == ST_OVERFLOW));

	always_comb begin
		case (op_s1)
			OP_ADDI: alu_s1 = sum_s1;
			OP_ANDI: alu_s1 = a_s1 & zimm_s1;
			OP_ORI:  alu_s1 = a_s1 | zimm_s1;
			OP_NORI: alu_s1 = ~(a_s1 | zimm_s1);
			OP_LUI:  alu_s1 = {imm_s1, 16'h0000};
			OP_SLTI: alu_s1 = {31'd0, ($signed(a_s1) < $signed(simm_s1))};
			default: alu_s1 = '0;
		endcase
	end

	// Stage 2 registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2     <= 1'b0;
			rf_we_s2 <= 1'b0;
			dm_we_s2 <= 1'b0;
		end else if (adv) begin
			v_s2     <= v_s1;
			rf_we_s2 <= commit_s1 && writes_s1;
			dm_we_s2 <= commit_s1 && stores_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2          <= op_s1;
			dst_s2         <= dst_s1;
			lane_s2        <= sum_s1[1:0];
			alu_s2         <= alu_s1;
			b_s2           <= b_s1;
			idx_s2         <= sum_s1[IDX_W+1:2];
			res_s2.mis     <= mis_s1;
			res_s2.aov     <= aov_s1;
			res_s2.nov     <= nov_s1;
			res_s2.zw      <= zw_s1;
			res_s2.status  <= status_s1;
			res_s2.next_pc <= taken_s1 ? (pc_s1 + {simm_s1[29:0], 2'b00}) : pc_s1;
		end
	end

	// Stage 2: load extraction and store merge on the data memory word.
	logic [31:0] st_word;
	logic [7:0]  ld_byte;
	logic [15:0] ld_half;

	assign ld_half = lane_s2[1] ? dm_rdata[31:16] : dm_rdata[15:0];

	always_comb begin
		case (lane_s2)
			2'd0:    ld_byte = dm_rdata[7:0];
			2'd1:    ld_byte = dm_rdata[15:8];
			2'd2:    ld_byte = dm_rdata[23:16];
			default: ld_byte = dm_rdata[31:24];
		endcase
	end

	always_comb begin
		case (op_s2)
			OP_LW:   s2_wdata = dm_rdata;
			OP_LH:   s2_wdata = sext16(ld_half);
			OP_LHU:  s2_wdata = {16'h0000, ld_half};
			OP_LB:   s2_wdata = sext8(ld_byte);
			OP_LBU:  s2_wdata = {24'h000000, ld_byte};
			default: s2_wdata = alu_s2;
		endcase
	end

	always_comb begin
		case (op_s2)
			OP_SH: begin
				st_word = lane_s2[1] ? {b_s2[15:0], dm_rdata[15:0]}
					: {dm_rdata[31:16], b_s2[15:0]};
			end
			OP_SB: begin
				case (lane_s2)
					2'd0:    st_word = {dm_rdata[31:8], b_s2[7:0]};
					2'd1:    st_word = {dm_rdata[31:16], b_s2[7:0], dm_rdata[7:0]};
					2'd2:    st_word = {dm_rdata[31:24], b_s2[7:0], dm_rdata[15:0]};
					default: st_word = {b_s2[7:0], dm_rdata[23:0]};
				endcase
			end
			default: st_word = b_s2;
		endcase
	end

	assign rf_wr.we   = s2_fwd_we;
	assign rf_wr.addr = dst_s2;
	assign rf_wr.data = s2_wdata;

	mie_dmem #(
		.WORDS (WORDS),
		.IDX_W (IDX_W)
	) u_dmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.rd_idx  (sum_s1[IDX_W+1:2]),
		.wr_en   (v_s2 && dm_we_s2),
		.wr_idx  (idx_s2),
		.wr_data (st_word),
		.rd_data (dm_rdata),
		.busy    (mem_busy)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res_s2;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {2'b00, out_q};

endmodule

### rtl/core/mie_checker.sv
// Port-level checker for the I-type execute core, bound to its top level.
// Depends on mie_pkg for status codes and on assert_macros.svh for the macros.
`include "assert_macros.svh"

module mie_checker import mie_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	logic    halt_flags;
	logic    skip_case;
	logic    ovf_case;
	status_t st;

	assign st         = status_t'(m_tdata[33:32]);
	assign halt_flags = m_tdata[36] || m_tdata[37];
	assign skip_case  = !halt_flags && m_tdata[34];
	assign ovf_case   = !halt_flags && !m_tdata[34] && m_tdata[35];

	// A held result word stays valid and unchanged.
	`ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result word dropped while stalled")
	`ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "held result word changed")

	// Status agrees with the fault flags reported beside it.
	`ASSERT_SAME(a_halt_flags, m_tvalid, (st == ST_HALT) == halt_flags, "halt status mismatch")
	`ASSERT_SAME(a_skip_prio, m_tvalid && skip_case, st == ST_SKIP, "skip not reported")
	`ASSERT_SAME(a_ovf_prio, m_tvalid && ovf_case, st == ST_OVERFLOW, "overflow not reported")

endmodule

bind mips_itype_execute_core mie_checker u_mie_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
